FILE: hw/rtl/tcse_pkg.sv
package tcse_pkg;

  localparam int NumConn = 8;
  localparam int IdxW = $clog2(NumConn);
  localparam int CntW = $clog2(NumConn + 1);

  // register byte addresses
  localparam logic [1:0] AddrHostIp = 2'd0;

  // tcp flag bits
  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic [15:0] HdrMin = 16'd20;

  typedef enum logic [1:0] {
    REQ_SEG    = 2'd0,
    REQ_OPEN   = 2'd1,
    REQ_LISTEN = 2'd2,
    REQ_BAD    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_NO_HNDL  = 3'd3,
    ST_RESET    = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    CS_CLOSED     = 3'd0,
    CS_LISTEN     = 3'd1,
    CS_SYN_SENT   = 3'd2,
    CS_SYN_RCVD   = 3'd3,
    CS_ESTAB      = 3'd4,
    CS_CLOSE_WAIT = 3'd5,
    CS_LAST_ACK   = 3'd6
  } conn_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'd0,
    FSM_SEARCH = 3'd1,
    FSM_EXEC   = 3'd2,
    FSM_OUT1   = 3'd3,
    FSM_OUT2   = 3'd4
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] seg_length;
    logic [3:0]  hdr_words;
    logic [31:0] new_iss;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  conn_index;
    logic        send_valid;
    logic [7:0]  send_flags;
    logic [31:0] send_seq;
    logic [31:0] send_ack;
    logic [15:0] send_src_port;
    logic [15:0] send_dst_port;
    logic [31:0] send_dst_ip;
    logic [15:0] deliver_len;
    logic        last;
  } res_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic search;
    logic exec;
    logic out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic two_res;
  } stat_t;

endpackage

FILE: hw/rtl/tcp_connection_state_engine.sv
// channel   dir  handshake             payload
// cfg       in   psel/penable/pready   host address at byte address 0
// s_axis    in   s_axis_tvalid/tready  request item, kind on tuser, 188 data bits
// m_axis    out  m_axis_tvalid/tready  result item, 159 data bits, tlast marks the final one
//
// an item passes through load, table search over all entries, read-modify-write of the
// chosen entry, then one output state per result (one or two), each waiting while the output is stalled.
// the single shared table update path serves every kind of request.
// reset clears every entry to closed and the allocation count; no clearing pass.
// a stalled output holds in its register; the block takes no new item until all
// results of the current one have entered it.
module tcp_connection_state_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // req_type
  input  logic [1:0]    s_axis_tuser,
  // peer_ip, peer_port, own_port, seg_flags, seg_seq, seg_ack,
  // seg_length, hdr_words, new_iss (lowest bit up)
  input  logic [191:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // status, conn_index, send_valid, send_flags, send_seq, send_ack, send_src_port,
  // send_dst_port, send_dst_ip, deliver_len (lowest bit up)
  output logic [159:0]  m_axis_tdata,
  output logic          m_axis_tlast
);

  logic [31:0] host_addr;
  tcse_pkg::req_item_t req_in;
  tcse_pkg::res_item_t res;
  tcse_pkg::cmd_t  cmd;
  tcse_pkg::stat_t stat;
  logic in_ready;
  logic res_push;
  logic in_fire;
  logic out_busy;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == tcse_pkg::AddrHostIp) ? host_addr : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      host_addr <= '0;
    end else if (psel && penable && pwrite && paddr == tcse_pkg::AddrHostIp) begin
      host_addr <= pwdata;
    end
  end

  // unpack request
  assign req_in.req_type    = s_axis_tuser;
  assign req_in.peer_ip     = s_axis_tdata[31:0];
  assign req_in.peer_port   = s_axis_tdata[47:32];
  assign req_in.own_port    = s_axis_tdata[63:48];
  assign req_in.seg_flags   = s_axis_tdata[71:64];
  assign req_in.seg_seq     = s_axis_tdata[103:72];
  assign req_in.seg_ack     = s_axis_tdata[135:104];
  assign req_in.seg_length  = s_axis_tdata[151:136];
  assign req_in.hdr_words   = s_axis_tdata[155:152];
  assign req_in.new_iss     = s_axis_tdata[187:156];

  assign s_axis_tready = in_ready;
  assign in_fire = s_axis_tvalid && in_ready;
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  tcse_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(out_busy),
    .stat(stat), .cmd(cmd), .in_ready(in_ready), .res_push(res_push)
  );

  tcse_datapath u_dp (
    .clk(clk), .rst(rst), .host_addr(host_addr), .req_in(req_in),
    .cmd(cmd), .stat(stat), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      m_axis_tdata <= {1'b0, res.deliver_len, res.send_dst_ip, res.send_dst_port,
                       res.send_src_port, res.send_ack, res.send_seq, res.send_flags,
                       res.send_valid, res.conn_index, res.status};
      m_axis_tlast <= res.last;
    end
  end

endmodule

FILE: hw/rtl/tcse_ctrl.sv
module tcse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic           out_busy,
  input  tcse_pkg::stat_t stat,
  output tcse_pkg::cmd_t cmd,
  output logic           in_ready,
  output logic           res_push
);

  tcse_pkg::fsm_t state;
  tcse_pkg::fsm_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcse_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    res_push = 1'b0;
    case (state)
      tcse_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire) state_next = tcse_pkg::FSM_SEARCH;
      end
      tcse_pkg::FSM_SEARCH: begin
        cmd.search = 1'b1;
        state_next = tcse_pkg::FSM_EXEC;
      end
      tcse_pkg::FSM_EXEC: begin
        cmd.exec = 1'b1;
        state_next = tcse_pkg::FSM_OUT1;
      end
      tcse_pkg::FSM_OUT1: begin
        if (!out_busy) begin
          res_push = 1'b1;
          state_next = stat.two_res ? tcse_pkg::FSM_OUT2 : tcse_pkg::FSM_IDLE;
        end
      end
      tcse_pkg::FSM_OUT2: begin
        cmd.out_sel = 1'b1;
        if (!out_busy) begin
          res_push = 1'b1;
          state_next = tcse_pkg::FSM_IDLE;
        end
      end
      default: state_next = tcse_pkg::FSM_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == tcse_pkg::FSM_SEARCH)
    else $error("load did not start search");
  assert property (@(posedge clk) disable iff (rst)
    res_push |-> !in_ready)
    else $error("push while idle");
  assert property (@(posedge clk) disable iff (rst)
    state == tcse_pkg::FSM_OUT2 |-> $past(stat.two_res))
    else $error("second result without need");

endmodule

FILE: hw/rtl/tcse_datapath.sv
module tcse_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          host_addr,
  input  tcse_pkg::req_item_t  req_in,
  input  tcse_pkg::cmd_t       cmd,
  output tcse_pkg::stat_t      stat,
  output tcse_pkg::res_item_t  res
);

  localparam int N = tcse_pkg::NumConn;
  localparam int IW = tcse_pkg::IdxW;

  // connection table
  logic [2:0]  c_state  [N];
  logic [15:0] c_lport  [N];
  logic [31:0] c_rip    [N];
  logic [15:0] c_rport  [N];
  logic [31:0] c_snxt   [N];
  logic [31:0] c_suna   [N];
  logic [31:0] c_rnxt   [N];
  logic [31:0] c_irs    [N];
  logic [31:0] c_lip    [N];
  logic [tcse_pkg::CntW-1:0] alloc_count;

  tcse_pkg::req_item_t rq;
  logic          found;
  logic [IW-1:0] idx;
  logic          bind_lsn;
  logic          full;
  logic          alloc_new;
  tcse_pkg::res_item_t r0;
  tcse_pkg::res_item_t r1;
  logic          two;

  // search results, combinational
  logic          s_found;
  logic [IW-1:0] s_idx;
  logic          s_bind;
  logic          a_found;
  logic [IW-1:0] a_idx;

  always_comb begin
    s_found = 1'b0;
    s_idx = '0;
    s_bind = 1'b0;
    a_found = 1'b0;
    a_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (i < int'(alloc_count) && c_state[i] != tcse_pkg::CS_CLOSED &&
          c_lip[i] == host_addr && c_lport[i] == rq.own_port) begin
        if (c_rip[i] == rq.peer_ip && c_rport[i] == rq.peer_port) begin
          s_found = 1'b1; s_idx = IW'(i); s_bind = 1'b0;
        end else if (c_rip[i] == '0 && c_rport[i] == '0) begin
          s_found = 1'b1; s_idx = IW'(i); s_bind = 1'b1;
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      if (i < int'(alloc_count) && c_state[i] == tcse_pkg::CS_CLOSED) begin
        a_found = 1'b1; a_idx = IW'(i);
      end
    end
  end

  // request and search registers
  always_ff @(posedge clk) begin
    if (cmd.load) rq <= req_in;
    if (cmd.search) begin
      if (rq.req_type == tcse_pkg::REQ_SEG) begin
        found <= s_found; idx <= s_idx; bind_lsn <= s_bind;
        full <= 1'b0; alloc_new <= 1'b0;
      end else begin
        found <= 1'b1; bind_lsn <= 1'b0;
        alloc_new <= !a_found;
        full <= !a_found && int'(alloc_count) >= N;
        idx <= a_found ? a_idx : IW'(alloc_count);
      end
    end
  end

  // execute: table update and result build
  logic [2:0]  e_state;
  logic [31:0] e_snxt, e_rnxt, e_rip, e_dlen32;
  logic [15:0] e_rport;
  logic [7:0]  fl;
  logic [17:0] hdr_bytes;
  logic        seg_ok_ack;

  function automatic tcse_pkg::res_item_t mk(input logic [2:0] st, input logic [2:0] ix);
    tcse_pkg::res_item_t r;
    r = '0;
    r.status = st;
    r.conn_index = ix;
    return r;
  endfunction

  function automatic tcse_pkg::res_item_t mks(input logic [2:0] ix, input logic [7:0] f,
      input logic [31:0] sq, input logic [31:0] ak, input logic [15:0] sp,
      input logic [15:0] dp, input logic [31:0] dip, input logic [15:0] dl);
    tcse_pkg::res_item_t r;
    r = '0;
    r.conn_index = ix;
    r.send_valid = 1'b1;
    r.send_flags = f;
    r.send_seq = sq;
    r.send_ack = (f & tcse_pkg::FlagAck) != '0 ? ak : 32'd0;
    r.send_src_port = sp;
    r.send_dst_port = dp;
    r.send_dst_ip = dip;
    r.deliver_len = dl;
    return r;
  endfunction

  assign fl = rq.seg_flags;
  assign hdr_bytes = {12'd0, rq.hdr_words, 2'b00};
  assign e_state = c_state[idx];
  assign e_snxt = c_snxt[idx];
  assign e_rnxt = c_rnxt[idx];
  assign e_rip = bind_lsn ? rq.peer_ip : c_rip[idx];
  assign e_rport = bind_lsn ? rq.peer_port : c_rport[idx];
  assign e_dlen32 = {16'd0, rq.seg_length} - {14'd0, hdr_bytes};
  assign seg_ok_ack = (fl & tcse_pkg::FlagAck) != '0 && rq.seg_ack == e_snxt;

  always_ff @(posedge clk) begin
    tcse_pkg::res_item_t r0_v;
    tcse_pkg::res_item_t r1_v;
    logic two_v;
    if (rst) begin
      for (int i = 0; i < N; i++) c_state[i] <= tcse_pkg::CS_CLOSED;
      alloc_count <= '0;
    end else if (cmd.exec) begin
      r0_v = mk(tcse_pkg::ST_IGNORED, 3'd0);
      r1_v = '0;
      two_v = 1'b0;
      case (rq.req_type)
        tcse_pkg::REQ_OPEN, tcse_pkg::REQ_LISTEN: begin
          if (full) begin
            r0_v = mk(tcse_pkg::ST_FULL, 3'd0);
          end else begin
            if (alloc_new) alloc_count <= alloc_count + 1'b1;
            c_lip[idx] <= host_addr;
            c_lport[idx] <= rq.own_port;
            c_rnxt[idx] <= '0;
            c_irs[idx] <= '0;
            if (rq.req_type == tcse_pkg::REQ_OPEN) begin
              c_rip[idx] <= rq.peer_ip;
              c_rport[idx] <= rq.peer_port;
              c_state[idx] <= tcse_pkg::CS_SYN_SENT;
              c_snxt[idx] <= rq.new_iss + 32'd1;
              c_suna[idx] <= rq.new_iss;
              r0_v = mks(3'(idx), tcse_pkg::FlagSyn, rq.new_iss, 32'd0, rq.own_port,
                         rq.peer_port, rq.peer_ip, 16'd0);
            end else begin
              c_rip[idx] <= '0;
              c_rport[idx] <= '0;
              c_snxt[idx] <= '0;
              c_suna[idx] <= '0;
              c_state[idx] <= tcse_pkg::CS_LISTEN;
              r0_v = mk(tcse_pkg::ST_OK, 3'(idx));
            end
          end
        end
        tcse_pkg::REQ_SEG: begin
          if (rq.seg_length < tcse_pkg::HdrMin) begin
            r0_v = mk(tcse_pkg::ST_SHORT, 3'd0);
          end else if (rq.hdr_words < 4'd5 || hdr_bytes > {2'd0, rq.seg_length}) begin
            r0_v = mk(tcse_pkg::ST_BAD_HDR, 3'd0);
          end else if (!found) begin
            r0_v = mk(tcse_pkg::ST_NO_HNDL, 3'd0);
          end else begin
            if (bind_lsn) begin
              c_rip[idx] <= rq.peer_ip;
              c_rport[idx] <= rq.peer_port;
            end
            r0_v = mk(tcse_pkg::ST_IGNORED, 3'(idx));
            if ((fl & tcse_pkg::FlagRst) != '0) begin
              c_state[idx] <= tcse_pkg::CS_CLOSED;
              r0_v = mk(tcse_pkg::ST_RESET, 3'(idx));
            end else begin
              case (e_state)
                tcse_pkg::CS_LISTEN: begin
                  if ((fl & tcse_pkg::FlagSyn) != '0) begin
                    c_irs[idx] <= rq.seg_seq;
                    c_rnxt[idx] <= rq.seg_seq + 32'd1;
                    c_snxt[idx] <= rq.new_iss + 32'd1;
                    c_state[idx] <= tcse_pkg::CS_SYN_RCVD;
                    r0_v = mks(3'(idx), tcse_pkg::FlagSyn | tcse_pkg::FlagAck, rq.new_iss,
                               rq.seg_seq + 32'd1, c_lport[idx], e_rport, e_rip, 16'd0);
                  end
                end
                tcse_pkg::CS_SYN_SENT: begin
                  if ((fl & tcse_pkg::FlagSyn) != '0 && seg_ok_ack) begin
                    c_state[idx] <= tcse_pkg::CS_ESTAB;
                    c_irs[idx] <= rq.seg_seq;
                    c_rnxt[idx] <= rq.seg_seq + 32'd1;
                    c_suna[idx] <= rq.seg_ack;
                    r0_v = mks(3'(idx), tcse_pkg::FlagAck, e_snxt, rq.seg_seq + 32'd1,
                               c_lport[idx], e_rport, e_rip, 16'd0);
                  end
                end
                tcse_pkg::CS_SYN_RCVD: begin
                  if (seg_ok_ack) begin
                    c_state[idx] <= tcse_pkg::CS_ESTAB;
                    c_suna[idx] <= rq.seg_ack;
                    r0_v = mk(tcse_pkg::ST_OK, 3'(idx));
                  end
                end
                tcse_pkg::CS_ESTAB: begin
                  // payload ack, then fin answer
                  if (e_dlen32 != '0) begin
                    r0_v = mks(3'(idx), tcse_pkg::FlagAck, e_snxt, e_rnxt + e_dlen32,
                               c_lport[idx], e_rport, e_rip, e_dlen32[15:0]);
                    if ((fl & tcse_pkg::FlagFin) != '0) begin
                      two_v = 1'b1;
                      r1_v = mks(3'(idx), tcse_pkg::FlagFin | tcse_pkg::FlagAck, e_snxt,
                                 e_rnxt + e_dlen32 + 32'd1, c_lport[idx], e_rport, e_rip,
                                 16'd0);
                      c_rnxt[idx] <= e_rnxt + e_dlen32 + 32'd1;
                      c_snxt[idx] <= e_snxt + 32'd1;
                      c_state[idx] <= tcse_pkg::CS_LAST_ACK;
                    end else begin
                      c_rnxt[idx] <= e_rnxt + e_dlen32;
                    end
                  end else if ((fl & tcse_pkg::FlagFin) != '0) begin
                    r0_v = mks(3'(idx), tcse_pkg::FlagFin | tcse_pkg::FlagAck, e_snxt,
                               e_rnxt + 32'd1, c_lport[idx], e_rport, e_rip, 16'd0);
                    c_rnxt[idx] <= e_rnxt + 32'd1;
                    c_snxt[idx] <= e_snxt + 32'd1;
                    c_state[idx] <= tcse_pkg::CS_LAST_ACK;
                  end else begin
                    r0_v = mk(tcse_pkg::ST_OK, 3'(idx));
                  end
                end
                tcse_pkg::CS_LAST_ACK: begin
                  if (seg_ok_ack) begin
                    c_state[idx] <= tcse_pkg::CS_CLOSED;
                    r0_v = mk(tcse_pkg::ST_OK, 3'(idx));
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: r0_v = mk(tcse_pkg::ST_IGNORED, 3'd0);
      endcase
      r0 <= r0_v;
      r1 <= r1_v;
      two <= two_v;
    end
  end

  assign stat.two_res = two;

  // result select with last mark
  always_comb begin
    res = cmd.out_sel ? r1 : r0;
    res.last = cmd.out_sel || !two;
  end

  assert property (@(posedge clk) disable iff (rst)
    int'(alloc_count) <= N)
    else $error("allocation count overflow");
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (two |-> r0.send_valid && r1.send_valid))
    else $error("second result without first send");
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec && full && (rq.req_type == tcse_pkg::REQ_OPEN ||
                         rq.req_type == tcse_pkg::REQ_LISTEN)
    |=> r0.status == tcse_pkg::ST_FULL)
    else $error("full table not reported");

endmodule

FILE: sim/tb.sv
module tb;

  // one expected result, optionally with a pinned status given by the stimulus
  typedef struct {
    tcse_pkg::res_item_t r;
    bit                  pinned;
    tcse_pkg::status_t   pinned_st;
  } expect_t;

  // directed stimulus row
  typedef struct {
    tcse_pkg::req_item_t it;
    bit                  pinned;
    tcse_pkg::status_t   st;
  } row_t;

  logic          clk;
  logic          rst;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [1:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // req_type
  logic [1:0]    s_axis_tuser;
  // peer_ip, peer_port, own_port, seg_flags, seg_seq, seg_ack,
  // seg_length, hdr_words, new_iss (lowest bit up)
  logic [191:0]  s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // status, conn_index, send_valid, send_flags, send_seq, send_ack, send_src_port,
  // send_dst_port, send_dst_ip, deliver_len (lowest bit up)
  logic [159:0]  m_axis_tdata;
  logic          m_axis_tlast;

  tcp_connection_state_engine i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // mirror of the connection table
  logic [31:0]           host_ip;
  tcse_pkg::conn_state_t tbl_state [tcse_pkg::NumConn];
  logic [15:0]   tbl_lport [tcse_pkg::NumConn];
  logic [31:0]   tbl_rip   [tcse_pkg::NumConn];
  logic [15:0]   tbl_rport [tcse_pkg::NumConn];
  logic [31:0]   tbl_snd_nxt [tcse_pkg::NumConn];
  logic [31:0]   tbl_snd_una [tcse_pkg::NumConn];
  logic [31:0]   tbl_rcv_nxt [tcse_pkg::NumConn];
  logic [31:0]   tbl_irs   [tcse_pkg::NumConn];
  logic [31:0]   tbl_lip   [tcse_pkg::NumConn];
  int            tbl_used;

  expect_t       pending_res [$];
  int            errors;
  int            n_items;
  int            n_results;
  int            n_pairs;
  int            n_full;
  bit            no_idle;
  row_t          rows [25];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tcp_connection_state_engine: mismatch");
    $finish;
  end

  function automatic tcse_pkg::req_item_t mk(input tcse_pkg::req_t rq,
                                   input logic [31:0] pip,
                                   input logic [15:0] pport, input logic [15:0] lport,
                                   input logic [7:0] fl, input logic [31:0] sq,
                                   input logic [31:0] ak, input logic [15:0] len,
                                   input logic [3:0] doff, input logic [31:0] iss);
    tcse_pkg::req_item_t it;
    it.req_type = rq;
    it.peer_ip = pip;
    it.peer_port = pport;
    it.own_port = lport;
    it.seg_flags = fl;
    it.seg_seq = sq;
    it.seg_ack = ak;
    it.seg_length = len;
    it.hdr_words = doff;
    it.new_iss = iss;
    return it;
  endfunction

  function automatic logic [191:0] pack_req(input tcse_pkg::req_item_t it);
    return {4'd0, it.new_iss, it.hdr_words, it.seg_length, it.seg_ack, it.seg_seq,
            it.seg_flags, it.own_port, it.peer_port, it.peer_ip};
  endfunction

  // result with no segment sent
  function automatic tcse_pkg::res_item_t plain_res(input tcse_pkg::status_t st,
                                                    input int idx);
    tcse_pkg::res_item_t r;
    r = '0;
    r.status = st;
    r.conn_index = idx[2:0];
    return r;
  endfunction

  // control segment built from the entry, advancing snd_nxt for syn/fin
  function automatic tcse_pkg::res_item_t seg_res(input int idx, input logic [7:0] fl,
                                                  input logic [15:0] dlen);
    tcse_pkg::res_item_t r;
    r = plain_res(tcse_pkg::ST_OK, idx);
    r.send_valid = 1'b1;
    r.send_flags = fl;
    r.send_seq = tbl_snd_nxt[idx];
    r.send_ack = (fl & tcse_pkg::FlagAck) != 0 ? tbl_rcv_nxt[idx] : 32'd0;
    r.send_src_port = tbl_lport[idx];
    r.send_dst_port = tbl_rport[idx];
    r.send_dst_ip = tbl_rip[idx];
    r.deliver_len = dlen;
    if ((fl & (tcse_pkg::FlagSyn | tcse_pkg::FlagFin)) != 0)
      tbl_snd_nxt[idx] = tbl_snd_nxt[idx] + 32'd1;
    return r;
  endfunction

  function automatic int grab_entry();
    int found;
    found = -1;
    for (int i = 0; i < tbl_used; i++)
      if (tbl_state[i] == tcse_pkg::CS_CLOSED) found = i;
    if (found < 0) begin
      if (tbl_used >= tcse_pkg::NumConn) return -1;
      found = tbl_used;
      tbl_used++;
    end
    tbl_state[found] = tcse_pkg::CS_CLOSED;
    tbl_lport[found] = '0;
    tbl_rip[found] = '0;
    tbl_rport[found] = '0;
    tbl_snd_nxt[found] = '0;
    tbl_snd_una[found] = '0;
    tbl_rcv_nxt[found] = '0;
    tbl_irs[found] = '0;
    tbl_lip[found] = '0;
    return found;
  endfunction

  // work out the results of one request and advance the table mirror
  function automatic void predict_conn(input tcse_pkg::req_item_t it,
                                       output tcse_pkg::res_item_t rs [2], output int n);
    int c;
    logic [31:0] dlen;
    c = -1;
    n = 0;
    rs[0] = '0;
    rs[1] = '0;
    if (it.req_type == tcse_pkg::REQ_OPEN || it.req_type == tcse_pkg::REQ_LISTEN) begin
      c = grab_entry();
      n = 1;
      if (c < 0) begin
        rs[0] = plain_res(tcse_pkg::ST_FULL, 0);
      end else begin
        tbl_lip[c] = host_ip;
        tbl_lport[c] = it.own_port;
        if (it.req_type == tcse_pkg::REQ_OPEN) begin
          tbl_rip[c] = it.peer_ip;
          tbl_rport[c] = it.peer_port;
          tbl_state[c] = tcse_pkg::CS_SYN_SENT;
          tbl_snd_nxt[c] = it.new_iss;
          tbl_snd_una[c] = it.new_iss;
          rs[0] = seg_res(c, tcse_pkg::FlagSyn, 16'd0);
        end else begin
          tbl_state[c] = tcse_pkg::CS_LISTEN;
          rs[0] = plain_res(tcse_pkg::ST_OK, c);
        end
      end
    end else if (it.req_type == tcse_pkg::REQ_BAD) begin
      rs[0] = plain_res(tcse_pkg::ST_IGNORED, 0);
      n = 1;
    end else if (it.seg_length < tcse_pkg::HdrMin) begin
      rs[0] = plain_res(tcse_pkg::ST_SHORT, 0);
      n = 1;
    end else if (it.hdr_words < 4'd5 || {10'd0, it.hdr_words, 2'b00} > it.seg_length) begin
      rs[0] = plain_res(tcse_pkg::ST_BAD_HDR, 0);
      n = 1;
    end else begin
      // table match: exact 4-tuple or an unbound listener
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_state[i] == tcse_pkg::CS_CLOSED || tbl_lip[i] != host_ip ||
            tbl_lport[i] != it.own_port) continue;
        if (tbl_rip[i] == it.peer_ip && tbl_rport[i] == it.peer_port) begin
          c = i;
          break;
        end
        if (tbl_rip[i] == 0 && tbl_rport[i] == 0) begin
          c = i;
          tbl_rip[i] = it.peer_ip;
          tbl_rport[i] = it.peer_port;
          break;
        end
      end
      if (c < 0) begin
        rs[0] = plain_res(tcse_pkg::ST_NO_HNDL, 0);
        n = 1;
      end else if ((it.seg_flags & tcse_pkg::FlagRst) != 0) begin
        tbl_state[c] = tcse_pkg::CS_CLOSED;
        rs[0] = plain_res(tcse_pkg::ST_RESET, c);
        n = 1;
      end else begin
        case (tbl_state[c])
          tcse_pkg::CS_LISTEN: begin
            if ((it.seg_flags & tcse_pkg::FlagSyn) != 0) begin
              tbl_irs[c] = it.seg_seq;
              tbl_rcv_nxt[c] = it.seg_seq + 32'd1;
              tbl_snd_nxt[c] = it.new_iss;
              tbl_state[c] = tcse_pkg::CS_SYN_RCVD;
              rs[0] = seg_res(c, tcse_pkg::FlagSyn | tcse_pkg::FlagAck, 16'd0);
              n = 1;
            end
          end
          tcse_pkg::CS_SYN_SENT: begin
            if ((it.seg_flags & tcse_pkg::FlagSyn) != 0 &&
                (it.seg_flags & tcse_pkg::FlagAck) != 0 &&
                it.seg_ack == tbl_snd_nxt[c]) begin
              tbl_state[c] = tcse_pkg::CS_ESTAB;
              tbl_irs[c] = it.seg_seq;
              tbl_rcv_nxt[c] = it.seg_seq + 32'd1;
              tbl_snd_una[c] = it.seg_ack;
              rs[0] = seg_res(c, tcse_pkg::FlagAck, 16'd0);
              n = 1;
            end
          end
          tcse_pkg::CS_SYN_RCVD: begin
            if ((it.seg_flags & tcse_pkg::FlagAck) != 0 &&
                it.seg_ack == tbl_snd_nxt[c]) begin
              tbl_state[c] = tcse_pkg::CS_ESTAB;
              tbl_snd_una[c] = it.seg_ack;
              rs[0] = plain_res(tcse_pkg::ST_OK, c);
              n = 1;
            end
          end
          tcse_pkg::CS_ESTAB: begin
            dlen = {16'd0, it.seg_length} - {26'd0, it.hdr_words, 2'b00};
            if (dlen != 0) begin
              tbl_rcv_nxt[c] = tbl_rcv_nxt[c] + dlen;
              rs[n] = seg_res(c, tcse_pkg::FlagAck, dlen[15:0]);
              n++;
            end
            if ((it.seg_flags & tcse_pkg::FlagFin) != 0) begin
              tbl_rcv_nxt[c] = tbl_rcv_nxt[c] + 32'd1;
              rs[n] = seg_res(c, tcse_pkg::FlagFin | tcse_pkg::FlagAck, 16'd0);
              tbl_state[c] = tcse_pkg::CS_LAST_ACK;
              n++;
            end
            if (n == 0) begin
              rs[0] = plain_res(tcse_pkg::ST_OK, c);
              n = 1;
            end
          end
          tcse_pkg::CS_LAST_ACK: begin
            if ((it.seg_flags & tcse_pkg::FlagAck) != 0 &&
                it.seg_ack == tbl_snd_nxt[c]) begin
              tbl_state[c] = tcse_pkg::CS_CLOSED;
              rs[0] = plain_res(tcse_pkg::ST_OK, c);
              n = 1;
            end
          end
          default: ;
        endcase
        if (n == 0) begin
          rs[0] = plain_res(tcse_pkg::ST_IGNORED, c);
          n = 1;
        end
      end
    end
    rs[n-1].last = 1'b1;
  endfunction

  // random request, mostly aimed at a live entry with a fitting segment
  function automatic tcse_pkg::req_item_t pick_request();
    tcse_pkg::req_item_t it;
    int pick;
    int live [$];
    int j;
    logic [31:0] dlen;
    it = mk(tcse_pkg::req_t'(2'($urandom_range(3))), $urandom, 16'($urandom),
            16'($urandom), 8'($urandom), $urandom, $urandom, 16'($urandom),
            4'($urandom), $urandom);
    pick = $urandom_range(99);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_state[i] != tcse_pkg::CS_CLOSED && tbl_lip[i] == host_ip) live.push_back(i);
    // raw noise
    if (pick < 10) return it;
    if (pick < 22 || live.size() == 0) begin
      it.req_type = tcse_pkg::REQ_OPEN;
      return it;
    end
    if (pick < 30) begin
      it.req_type = tcse_pkg::REQ_LISTEN;
      return it;
    end
    j = live[$urandom_range(live.size() - 1)];
    it.req_type = tcse_pkg::REQ_SEG;
    it.own_port = tbl_lport[j];
    if (tbl_rip[j] != 0 || tbl_rport[j] != 0) begin
      it.peer_ip = tbl_rip[j];
      it.peer_port = tbl_rport[j];
    end
    it.seg_ack = tbl_snd_nxt[j];
    it.hdr_words = 4'($urandom_range(15, 5));
    dlen = 0;
    case (tbl_state[j])
      tcse_pkg::CS_LISTEN:
        it.seg_flags = 8'(tcse_pkg::FlagSyn | ($urandom & 8'hEB));
      tcse_pkg::CS_SYN_SENT:
        it.seg_flags = 8'(tcse_pkg::FlagSyn | tcse_pkg::FlagAck | ($urandom & 8'hE9));
      tcse_pkg::CS_ESTAB: begin
        it.seg_flags = 8'(tcse_pkg::FlagAck |
                          ($urandom_range(9) < 3 ? tcse_pkg::FlagFin : 8'h00) |
                          ($urandom & 8'hE8));
        dlen = $urandom_range(3) == 0 ? 0 :
               ($urandom_range(19) == 0 ? $urandom_range(65475) : $urandom_range(100));
      end
      default:
        it.seg_flags = 8'(tcse_pkg::FlagAck | ($urandom & 8'hE8));
    endcase
    it.seg_length = 16'({26'd0, it.hdr_words, 2'b00} + dlen);
    // occasional reset, bad ack or broken header
    if ($urandom_range(19) == 0) it.seg_flags = it.seg_flags | tcse_pkg::FlagRst;
    if ($urandom_range(9) == 0) it.seg_ack = $urandom;
    if ($urandom_range(19) == 0) it.seg_length = 16'($urandom_range(30));
    return it;
  endfunction

  // send one item, idling at random, and predict it once accepted
  task automatic send_item(input tcse_pkg::req_item_t it, input bit pinned,
                           input tcse_pkg::status_t st);
    tcse_pkg::res_item_t rs [2];
    int n;
    expect_t e;
    bit taken;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      if (!no_idle && $urandom_range(99) < 18) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.req_type;
        s_axis_tdata <= pack_req(it);
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        taken = 1;
      end
    end
    predict_conn(it, rs, n);
    for (int k = 0; k < n; k++) begin
      e.r = rs[k];
      e.pinned = pinned && k == 0;
      e.pinned_st = st;
      pending_res.push_back(e);
    end
    n_items++;
    if (n == 2) n_pairs++;
    if (rs[0].status == tcse_pkg::ST_FULL) n_full++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_host_ip(input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= tcse_pkg::AddrHostIp;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    host_ip = v;
  endtask

  // reset every live entry of the current address so the table frees up
  task automatic close_all();
    int j;
    tcse_pkg::req_item_t it;
    j = 0;
    while (j >= 0) begin
      j = -1;
      for (int i = tbl_used - 1; i >= 0; i--)
        if (tbl_state[i] != tcse_pkg::CS_CLOSED && tbl_lip[i] == host_ip) j = i;
      if (j >= 0) begin
        it = mk(tcse_pkg::REQ_SEG, tbl_rip[j], tbl_rport[j], tbl_lport[j],
                tcse_pkg::FlagRst | tcse_pkg::FlagAck,
                $urandom, $urandom, 16'd20, 4'd5, $urandom);
        if (tbl_rip[j] == 0 && tbl_rport[j] == 0) it.peer_ip = $urandom;
        send_item(it, 1'b1, tcse_pkg::ST_RESET);
      end
    end
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || $urandom_range(99) >= 18;
    end
  end

  // result checking
  always @(posedge clk) begin
    expect_t e;
    tcse_pkg::res_item_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[2:0];
      got.conn_index = m_axis_tdata[5:3];
      got.send_valid = m_axis_tdata[6];
      got.send_flags = m_axis_tdata[14:7];
      got.send_seq = m_axis_tdata[46:15];
      got.send_ack = m_axis_tdata[78:47];
      got.send_src_port = m_axis_tdata[94:79];
      got.send_dst_port = m_axis_tdata[110:95];
      got.send_dst_ip = m_axis_tdata[142:111];
      got.deliver_len = m_axis_tdata[158:143];
      got.last = m_axis_tlast;
      n_results++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (got != e.r) begin
          $display("%0t: expected %p", $time, e.r);
          $display("%0t: actual   %p", $time, got);
          errors++;
        end
        if (e.pinned && got.status != e.pinned_st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.pinned_st, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] ips [3];
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_pairs = 0;
    n_full = 0;
    no_idle = 0;
    host_ip = '0;
    tbl_used = 0;
    for (int i = 0; i < tcse_pkg::NumConn; i++) begin
      tbl_state[i] = tcse_pkg::CS_CLOSED;
      tbl_lport[i] = '0;
      tbl_rip[i] = '0;
      tbl_rport[i] = '0;
      tbl_snd_nxt[i] = '0;
      tbl_snd_una[i] = '0;
      tbl_rcv_nxt[i] = '0;
      tbl_irs[i] = '0;
      tbl_lip[i] = '0;
    end
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = '0;
    s_axis_tdata = '0;

    // directed table: rejects, a passive open through close, two active opens, fill-up
    rows[0]  = '{mk(tcse_pkg::REQ_BAD, 1, 2, 3, 8'hFF, 0, 0, 16'hFFFF, 4'hF, 0),
                 1, tcse_pkg::ST_IGNORED};
    rows[1]  = '{mk(tcse_pkg::REQ_SEG, 1, 2, 3, 0, 0, 0, 16'd19, 4'd4, 0),
                 1, tcse_pkg::ST_SHORT};
    rows[2]  = '{mk(tcse_pkg::REQ_SEG, 1, 2, 3, 0, 0, 0, 16'd20, 4'd4, 0),
                 1, tcse_pkg::ST_BAD_HDR};
    rows[3]  = '{mk(tcse_pkg::REQ_SEG, 1, 2, 3, 0, 0, 0, 16'd20, 4'd6, 0),
                 1, tcse_pkg::ST_BAD_HDR};
    rows[4]  = '{mk(tcse_pkg::REQ_SEG, 1, 2, 3, 0, 0, 0, 16'd20, 4'd5, 0),
                 1, tcse_pkg::ST_NO_HNDL};
    rows[5]  = '{mk(tcse_pkg::REQ_LISTEN, 0, 0, 80, 0, 0, 0, 0, 0, 0), 1, tcse_pkg::ST_OK};
    rows[6]  = '{mk(tcse_pkg::REQ_SEG, 32'h01020304, 1000, 80, tcse_pkg::FlagSyn, 100, 0,
                    20, 5, 500), 0, tcse_pkg::ST_OK};
    rows[7]  = '{mk(tcse_pkg::REQ_SEG, 32'h01020304, 1000, 80, tcse_pkg::FlagAck, 101, 501,
                    20, 5, 0), 0, tcse_pkg::ST_OK};
    rows[8]  = '{mk(tcse_pkg::REQ_SEG, 32'h01020304, 1000, 80, tcse_pkg::FlagAck, 101, 501,
                    20, 5, 0), 1, tcse_pkg::ST_OK};
    rows[9]  = '{mk(tcse_pkg::REQ_SEG, 32'h01020304, 1000, 80,
                    tcse_pkg::FlagFin | tcse_pkg::FlagAck, 101, 501, 60, 5, 0),
                 0, tcse_pkg::ST_OK};
    rows[10] = '{mk(tcse_pkg::REQ_SEG, 32'h01020304, 1000, 80, tcse_pkg::FlagAck, 142, 502,
                    20, 5, 0), 0, tcse_pkg::ST_OK};
    rows[11] = '{mk(tcse_pkg::REQ_OPEN, '1, '1, '1, 0, 0, 0, 0, 0, '1), 0, tcse_pkg::ST_OK};
    rows[12] = '{mk(tcse_pkg::REQ_SEG, '1, '1, '1, tcse_pkg::FlagSyn | tcse_pkg::FlagAck,
                    '1, 0, 20, 5, 0), 0, tcse_pkg::ST_OK};
    rows[13] = '{mk(tcse_pkg::REQ_SEG, '1, '1, '1, 8'h00, 0, 0, 16'hFFFF, 4'hF, 0),
                 0, tcse_pkg::ST_OK};
    rows[14] = '{mk(tcse_pkg::REQ_SEG, '1, '1, '1, tcse_pkg::FlagRst, 0, 0, 20, 5, 0),
                 1, tcse_pkg::ST_RESET};
    rows[15] = '{mk(tcse_pkg::REQ_OPEN, 32'h05060708, 22, 3000, 0, 0, 0, 0, 0, 7),
                 0, tcse_pkg::ST_OK};
    rows[16] = '{mk(tcse_pkg::REQ_SEG, 32'h05060708, 22, 3000,
                    tcse_pkg::FlagSyn | tcse_pkg::FlagAck, 9, 99, 20, 5, 0),
                 1, tcse_pkg::ST_IGNORED};
    for (int k = 17; k < 24; k++)
      rows[k] = '{mk(tcse_pkg::REQ_OPEN, 32'h0A000000 + k, 16'(4000 + k), 16'(5000 + k),
                     0, 0, 0, 0, 0, 32'h10000 * k), 0, tcse_pkg::ST_OK};
    rows[24] = '{mk(tcse_pkg::REQ_OPEN, 32'h0B000001, 1, 1, 0, 0, 0, 0, 0, 0),
                 1, tcse_pkg::ST_FULL};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[k]) send_item(rows[k].it, rows[k].pinned, rows[k].st);
    close_all();
    drain();

    // random phases, each under its own host address
    ips[0] = '1;
    ips[1] = $urandom;
    ips[2] = '0;
    for (int ph = 0; ph < 3; ph++) begin
      write_host_ip(ips[ph]);
      for (int k = 0; k < 310; k++) begin
        no_idle = ph == 1 && k >= 100 && k < 220;
        send_item(pick_request(), 1'b0, tcse_pkg::ST_OK);
        // hold off until the block is fully drained
        if (k == 150) begin
          @(negedge clk);
          s_axis_tvalid <= 1'b0;
          while (pending_res.size() != 0) @(posedge clk);
        end
      end
      no_idle = 0;
      close_all();
      drain();
    end

    $display("%0d requests sent, %0d results checked, %0d double results, %0d table-full",
             n_items, n_results, n_pairs, n_full);
    $display("host address written to all-ones, random and zero between phases");
    if (errors == 0) begin
      $display("tcp_connection_state_engine: match");
    end else begin
      $display("tcp_connection_state_engine: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tcse_pkg.sv
hw/rtl/tcse_ctrl.sv
hw/rtl/tcse_datapath.sv
hw/rtl/tcp_connection_state_engine.sv
sim/tb.sv
